>>> rtl/core/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

	localparam int DEPTH  = 8;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// request codes as they arrive on the request channel
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_DISP = 2'd2,
		OP_SORT = 2'd3
	} op_t;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// classified request between front and back
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISP,
		ST_SLOAD,
		ST_SEMIT
	} state_t;

endpackage

>>> rtl/core/bss_req_if.sv
`timescale 1ns / 1ps

interface bss_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        req_type;
	logic signed [bss_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

>>> rtl/core/bss_rsp_if.sv
`timescale 1ns / 1ps

interface bss_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [bss_pkg::DATA_W-1:0] data_value;
	logic                              last;

	modport source (output valid, output status, output data_value, output last, input ready);
	modport sink (input valid, input status, input data_value, input last, output ready);
endinterface

>>> rtl/core/bss_front.sv
`timescale 1ns / 1ps

module bss_front (
	input  logic          clk,
	input  logic          arst_n,
	bss_req_if.sink       req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output bss_pkg::cmd_t cmd
);

	logic          v_q;
	bss_pkg::cmd_t cmd_q;

	assign req.ready = !v_q || cmd_ready;
	assign cmd_valid = v_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (req.ready) begin
			v_q <= req.valid;
		end
	end

	// classify: decode the request code, keep the value only for a push
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_q.op <= bss_pkg::op_t'(req.req_type);
			if (bss_pkg::op_t'(req.req_type) == bss_pkg::OP_PUSH) begin
				cmd_q.value <= req.push_value;
			end else begin
				cmd_q.value <= '0;
			end
		end
	end

endmodule

>>> rtl/core/bss_fifo.sv
`timescale 1ns / 1ps

module bss_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  bss_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output bss_pkg::cmd_t rd_data
);

	bss_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/core/bss_back.sv
`timescale 1ns / 1ps

module bss_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  bss_pkg::cmd_t cmd,
	bss_rsp_if.source     rsp
);

	localparam int DEPTH = bss_pkg::DEPTH;
	localparam int CNT_W = bss_pkg::CNT_W;
	localparam int IDX_W = bss_pkg::IDX_W;
	localparam int DW    = bss_pkg::DATA_W;

	bss_pkg::state_t state_q;
	bss_pkg::state_t state_nxt;

	logic signed [DW-1:0] stk_q [DEPTH];
	logic signed [DW-1:0] srt_q [DEPTH];
	logic signed [DW-1:0] srt_nxt [DEPTH];
	logic [DEPTH-1:0]     le;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 ov_q;
	logic [1:0]           o_status_q;
	logic signed [DW-1:0] o_data_q;
	logic                 o_last_q;

	logic                 out_free;
	logic                 is_full;
	logic                 is_empty;
	logic                 idx_last;
	logic [CNT_W-1:0]     rd_off;
	logic [IDX_W-1:0]     rd_addr;
	logic signed [DW-1:0] rd_data;

	// datapath controls
	logic                 emit;
	logic [1:0]           e_status;
	logic signed [DW-1:0] e_data;
	logic                 e_last;
	logic                 stk_wr;
	logic                 cnt_inc;
	logic                 cnt_dec;
	logic                 cnt_clr;
	logic                 idx_clr;
	logic                 idx_inc;
	logic                 srt_ld;

	assign out_free = !ov_q || rsp.ready;
	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

	// read address: top minus index while idle or displaying, index while loading
	always_comb begin
		if (state_q == bss_pkg::ST_SLOAD) begin
			rd_off = CNT_W'(idx_q);
		end else begin
			rd_off = cnt_q - CNT_W'(1) - CNT_W'(idx_q);
		end
	end
	assign rd_addr = rd_off[IDX_W-1:0];
	assign rd_data = stk_q[rd_addr];

	// insertion row: each cell keeps, takes the new value or takes its left neighbour
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		assign le[k] = (CNT_W'(k) < CNT_W'(idx_q)) && (srt_q[k] <= rd_data);
		if (k == 0) begin : g_first
			assign srt_nxt[k] = le[k] ? srt_q[k] : rd_data;
		end else begin : g_rest
			assign srt_nxt[k] = le[k] ? srt_q[k] : (le[k-1] ? rd_data : srt_q[k-1]);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bss_pkg::ST_IDLE: begin
				if (cmd_valid && !is_empty) begin
					if (cmd.op == bss_pkg::OP_DISP) begin
						state_nxt = bss_pkg::ST_DISP;
					end else if (cmd.op == bss_pkg::OP_SORT) begin
						state_nxt = bss_pkg::ST_SLOAD;
					end
				end
			end
			bss_pkg::ST_DISP: begin
				if (out_free && idx_last) begin
					state_nxt = bss_pkg::ST_IDLE;
				end
			end
			bss_pkg::ST_SLOAD: begin
				if (idx_last) begin
					state_nxt = bss_pkg::ST_SEMIT;
				end
			end
			bss_pkg::ST_SEMIT: begin
				if (out_free && idx_last) begin
					state_nxt = bss_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bss_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_ready = 1'b0;
		emit      = 1'b0;
		e_status  = bss_pkg::ST_OK;
		e_data    = '0;
		e_last    = 1'b1;
		stk_wr    = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		cnt_clr   = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		srt_ld    = 1'b0;
		case (state_q)
			bss_pkg::ST_IDLE: begin
				idx_clr = 1'b1;
				if (cmd_valid) begin
					if (cmd.op == bss_pkg::OP_PUSH) begin
						if (out_free) begin
							cmd_ready = 1'b1;
							emit      = 1'b1;
							if (is_full) begin
								e_status = bss_pkg::ST_FULL;
							end else begin
								stk_wr  = 1'b1;
								cnt_inc = 1'b1;
							end
						end
					end else if (is_empty) begin
						if (out_free) begin
							cmd_ready = 1'b1;
							emit      = 1'b1;
							e_status  = bss_pkg::ST_EMPTY;
						end
					end else if (cmd.op == bss_pkg::OP_POP) begin
						if (out_free) begin
							cmd_ready = 1'b1;
							emit      = 1'b1;
							e_data    = rd_data;
							cnt_dec   = 1'b1;
						end
					end else begin
						// display or sort on a non-empty stack: take it and run
						cmd_ready = 1'b1;
					end
				end
			end
			bss_pkg::ST_DISP: begin
				if (out_free) begin
					emit    = 1'b1;
					e_data  = rd_data;
					e_last  = idx_last;
					idx_inc = !idx_last;
					idx_clr = idx_last;
				end
			end
			bss_pkg::ST_SLOAD: begin
				srt_ld = 1'b1;
				if (idx_last) begin
					idx_clr = 1'b1;
				end else begin
					idx_inc = 1'b1;
				end
			end
			bss_pkg::ST_SEMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					e_data  = srt_q[idx_q];
					e_last  = idx_last;
					idx_inc = !idx_last;
					idx_clr = idx_last;
					cnt_clr = idx_last;
				end
			end
			default: begin
				idx_clr = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stk_wr) begin
			stk_q[cnt_q[IDX_W-1:0]] <= cmd.value;
		end
		if (srt_ld) begin
			srt_q <= srt_nxt;
		end
		if (emit) begin
			o_status_q <= e_status;
			o_data_q   <= e_data;
			o_last_q   <= e_last;
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.status     = o_status_q;
	assign rsp.data_value = o_data_q;
	assign rsp.last       = o_last_q;

endmodule

>>> rtl/core/bounded_stack_with_sort.sv
`timescale 1ns / 1ps

// bounded stack of signed 32-bit words with display and sort
// req channel: one request per handshake (push, pop, display and sort)
// rsp channel: result items with status, data_value and last; last marks the
//   final result of a request
// the front stage registers and decodes each request and hands it through a
//   two-entry queue to the back end, so new requests are taken while the back
//   end is busy or the receiver stalls
// each request passes the front register, the queue and the back end's result
//   register before its first result is offered
// throughput is set by the back-end sequencer and its single read port: the back
//   end takes a new request only once the last result of the current one is offered;
//   display reads its results one by one from the stack, and sort first inserts every
//   entry into the sorting row, then offers the row from its first cell to its last
// sort leaves the stack empty and keeps every copy of equal values
// reset empties the stack and the queue and drops any pending result;
//   the storage itself is not cleared
// when the receiver holds ready low the result register keeps its item and the
//   back end waits; requests keep flowing in until the queue is full
module bounded_stack_with_sort (
	input  logic      clk,
	input  logic      arst_n,
	bss_req_if.sink   req,
	bss_rsp_if.source rsp
);

	// front to queue
	logic          f_valid;
	logic          f_ready;
	bss_pkg::cmd_t f_cmd;

	// queue to back end
	logic          b_valid;
	logic          b_ready;
	bss_pkg::cmd_t b_cmd;

	bss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	bss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_cmd)
	);

	bss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.rsp       (rsp)
	);

endmodule
